FILE: sv/arpi_pkg.sv
package arpi_pkg;

  localparam int unsigned PORT_W    = 5;
  localparam int unsigned VLAN_W    = 12;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned IP_W      = 32;
  localparam int unsigned VERDICT_W = 4;
  localparam int unsigned OUT_CNT_W = 32;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned SLOTS     = 5;
  localparam int unsigned SLOT_W    = 3;

  localparam int unsigned NUM_PORTS_DEF   = 32;
  localparam int unsigned NUM_VLANS_DEF   = 4096;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam logic [IP_W-1:0] IP_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [IP_W-1:0] IP_CLASS_DE = 32'hE000_0000;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_INSPECT_ENABLE = 3'd0;
  localparam logic [2:0] REG_TRUSTED        = 3'd1;
  localparam logic [2:0] REG_SMAC_CHECK     = 3'd2;
  localparam logic [2:0] REG_TMAC_CHECK     = 3'd3;
  localparam logic [2:0] REG_IP_CHECK       = 3'd4;
  localparam logic [2:0] REG_ZERO_IP_OK     = 3'd5;

  typedef enum logic [VERDICT_W-1:0] {
    V_FWD        = 4'd0,
    V_FWD_UNINSP = 4'd1,
    V_OFF        = 4'd2,
    V_STP        = 4'd3,
    V_OWN_MAC    = 4'd4,
    V_SMAC       = 4'd5,
    V_DMAC       = 4'd6,
    V_SIP        = 4'd7,
    V_DIP        = 4'd8
  } verdict_e;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_FWD  = 3'd0,
    SLOT_SMAC = 3'd1,
    SLOT_DMAC = 3'd2,
    SLOT_SIP  = 3'd3,
    SLOT_DIP  = 3'd4
  } slot_e;

  typedef struct packed {
    logic             inspect_enable;
    logic [REG_W-1:0] trusted;
    logic [REG_W-1:0] smac_check;
    logic [REG_W-1:0] tmac_check;
    logic [REG_W-1:0] ip_check;
    logic [REG_W-1:0] zero_ip_ok;
  } cfg_t;

  typedef struct packed {
    verdict_e verdict;
    logic     counted;
    slot_e    slot;
  } judge_t;

  function automatic logic ip_bad(input logic [IP_W-1:0] ip, input logic zero_ok);
    logic bad;
    bad = (ip == IP_ALL_ONES) || ((ip & IP_CLASS_DE) == IP_CLASS_DE) ||
          (!zero_ok && (ip == '0));
    return bad;
  endfunction

endpackage

FILE: sv/arpi_if.sv
interface arpi_in_if;
  import arpi_pkg::*;

  logic                valid;
  logic                ready;
  logic [PORT_W-1:0]   src_port;
  logic [VLAN_W-1:0]   vlan_id;
  logic                vlan_inspected;
  logic                stp_forwarding;
  logic                to_own_mac;
  logic                is_reply;
  logic [MAC_W-1:0]    eth_src_mac;
  logic [MAC_W-1:0]    eth_dst_mac;
  logic [MAC_W-1:0]    sender_mac;
  logic [MAC_W-1:0]    target_mac;
  logic [IP_W-1:0]     sender_ip;
  logic [IP_W-1:0]     target_ip;

  modport source (
    output valid, src_port, vlan_id, vlan_inspected, stp_forwarding, to_own_mac,
    output is_reply, eth_src_mac, eth_dst_mac, sender_mac, target_mac,
    output sender_ip, target_ip,
    input  ready
  );

  modport sink (
    input  valid, src_port, vlan_id, vlan_inspected, stp_forwarding, to_own_mac,
    input  is_reply, eth_src_mac, eth_dst_mac, sender_mac, target_mac,
    input  sender_ip, target_ip,
    output ready
  );
endinterface

interface arpi_out_if;
  import arpi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [OUT_CNT_W-1:0] port_count;
  logic [OUT_CNT_W-1:0] vlan_count;

  modport source (output valid, verdict, port_count, vlan_count, input ready);
  modport sink   (input valid, verdict, port_count, vlan_count, output ready);
endinterface

FILE: sv/arpi_cfg.sv
module arpi_cfg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [arpi_pkg::PADDR_W-1:0] paddr,
  input  logic [arpi_pkg::REG_W-1:0]   pwdata,
  output logic [arpi_pkg::REG_W-1:0]   prdata,
  output logic                   pready,
  output arpi_pkg::cfg_t         cfg_o
);
  import arpi_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_INSPECT_ENABLE: cfg_d.inspect_enable = pwdata[0];
        REG_TRUSTED:        cfg_d.trusted        = pwdata;
        REG_SMAC_CHECK:     cfg_d.smac_check     = pwdata;
        REG_TMAC_CHECK:     cfg_d.tmac_check     = pwdata;
        REG_IP_CHECK:       cfg_d.ip_check       = pwdata;
        REG_ZERO_IP_OK:     cfg_d.zero_ip_ok     = pwdata;
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_INSPECT_ENABLE: prdata = {{(REG_W-1){1'b0}}, cfg_q.inspect_enable};
      REG_TRUSTED:        prdata = cfg_q.trusted;
      REG_SMAC_CHECK:     prdata = cfg_q.smac_check;
      REG_TMAC_CHECK:     prdata = cfg_q.tmac_check;
      REG_IP_CHECK:       prdata = cfg_q.ip_check;
      REG_ZERO_IP_OK:     prdata = cfg_q.zero_ip_ok;
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

FILE: sv/arpi_judge.sv
module arpi_judge (
  input  arpi_pkg::cfg_t              cfg_i,
  input  logic [arpi_pkg::PORT_W-1:0] src_port_i,
  input  logic                        vlan_inspected_i,
  input  logic                        stp_forwarding_i,
  input  logic                        to_own_mac_i,
  input  logic                        is_reply_i,
  input  logic [arpi_pkg::MAC_W-1:0]  eth_src_mac_i,
  input  logic [arpi_pkg::MAC_W-1:0]  eth_dst_mac_i,
  input  logic [arpi_pkg::MAC_W-1:0]  sender_mac_i,
  input  logic [arpi_pkg::MAC_W-1:0]  target_mac_i,
  input  logic [arpi_pkg::IP_W-1:0]   sender_ip_i,
  input  logic [arpi_pkg::IP_W-1:0]   target_ip_i,
  output arpi_pkg::judge_t            judge_o
);
  import arpi_pkg::*;

  logic trusted, smac_chk, tmac_chk, ip_chk, zero_ok;
  verdict_e verdict;

  assign trusted  = cfg_i.trusted[src_port_i];
  assign smac_chk = cfg_i.smac_check[src_port_i];
  assign tmac_chk = cfg_i.tmac_check[src_port_i];
  assign ip_chk   = cfg_i.ip_check[src_port_i];
  assign zero_ok  = cfg_i.zero_ip_ok[src_port_i];

  always_comb begin
    if (!cfg_i.inspect_enable) begin
      verdict = V_OFF;
    end else if (!stp_forwarding_i) begin
      verdict = V_STP;
    end else if (to_own_mac_i) begin
      verdict = V_OWN_MAC;
    end else if (!vlan_inspected_i) begin
      verdict = V_FWD_UNINSP;
    end else if (trusted) begin
      verdict = V_FWD;
    end else if (smac_chk && (sender_mac_i != eth_src_mac_i)) begin
      verdict = V_SMAC;
    end else if (is_reply_i && tmac_chk && (target_mac_i != eth_dst_mac_i)) begin
      verdict = V_DMAC;
    end else if (ip_chk && ip_bad(sender_ip_i, zero_ok)) begin
      verdict = V_SIP;
    end else if (ip_chk && is_reply_i && ip_bad(target_ip_i, zero_ok)) begin
      verdict = V_DIP;
    end else begin
      verdict = V_FWD;
    end
  end

  always_comb begin
    judge_o.verdict = verdict;
    judge_o.counted = 1'b1;
    case (verdict)
      V_FWD:   judge_o.slot = SLOT_FWD;
      V_SMAC:  judge_o.slot = SLOT_SMAC;
      V_DMAC:  judge_o.slot = SLOT_DMAC;
      V_SIP:   judge_o.slot = SLOT_SIP;
      V_DIP:   judge_o.slot = SLOT_DIP;
      default: begin
        judge_o.slot    = SLOT_FWD;
        judge_o.counted = 1'b0;
      end
    endcase
  end
endmodule

FILE: sv/arpi_bank.sv
module arpi_bank #(
  parameter int unsigned ROWS        = 32,
  parameter int unsigned IDX_W       = 5,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        take_i,
  input  logic                        use_i,
  input  logic [IDX_W-1:0]            idx_i,
  input  arpi_pkg::slot_e             slot_i,
  input  logic                        adv_i,
  output logic [COUNT_WIDTH-1:0]      count_o,
  output logic                        busy_o
);
  import arpi_pkg::*;

  localparam int unsigned DEPTH  = ROWS * SLOTS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned FULL_W = (ADDR_W > IDX_W + 3) ? ADDR_W : IDX_W + 3;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];

  logic [FULL_W-1:0]      full_addr;
  logic [ADDR_W-1:0]      raddr;
  logic [ADDR_W-1:0]      addr_q;
  logic                   use_q;
  logic                   fwd_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic [COUNT_WIDTH-1:0] wdata;
  logic                   wr_fire;
  logic                   clr_q, clr_d;
  logic [ADDR_W-1:0]      clr_addr_q, clr_addr_d;
  logic                   we;
  logic [ADDR_W-1:0]      wa;
  logic [COUNT_WIDTH-1:0] wd;

  // entry address is row * 5 + slot
  assign full_addr = (FULL_W'(idx_i) << 2) + FULL_W'(idx_i) + FULL_W'(slot_i);
  assign raddr     = full_addr[ADDR_W-1:0];

  assign wr_fire = adv_i && use_q;
  assign wdata   = (fwd_q ? fwd_data_q : rdata_q) + COUNT_WIDTH'(1);
  assign count_o = use_q ? wdata : '0;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_comb begin
    we = clr_q || wr_fire;
    wa = clr_q ? clr_addr_q : addr_q;
    wd = clr_q ? '0 : wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      use_q      <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      if (take_i) begin
        use_q <= use_i;
        // item written in this same cycle: the read below sees the old value
        fwd_q <= wr_fire && (addr_q == raddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      addr_q     <= raddr;
      fwd_data_q <= wdata;
      rdata_q    <= mem[raddr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  assign busy_o = clr_q;
endmodule

FILE: sv/arp_packet_inspection.sv
// an accepted item passes the s1 register, then the output register;
// throughput: one item per cycle unless the output stalls, set by the
//   counter read-modify-write, which forwards the value written by the
//   item just ahead; reset: valid flags and config clear to zero, and the
//   counter memories run a clearing pass before the first item is taken
module arp_packet_inspection #(
  parameter int unsigned NUM_PORTS   = arpi_pkg::NUM_PORTS_DEF,
  parameter int unsigned NUM_VLANS   = arpi_pkg::NUM_VLANS_DEF,
  parameter int unsigned COUNT_WIDTH = arpi_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  arpi_in_if.sink                      in_i,
  arpi_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arpi_pkg::PADDR_W-1:0] paddr,
  input  logic [arpi_pkg::REG_W-1:0]   pwdata,
  output logic [arpi_pkg::REG_W-1:0]   prdata,
  output logic                         pready
);
  import arpi_pkg::*;

  cfg_t     cfg;
  judge_t   jdg;
  logic     accept, adv;
  logic     port_busy, vlan_busy;
  logic     port_ok, vlan_ok;
  logic     s1_valid_q;
  verdict_e s1_verdict_q;
  logic     out_valid_q;
  verdict_e out_verdict_q;
  logic [OUT_CNT_W-1:0]   out_pcnt_q, out_vcnt_q;
  logic [COUNT_WIDTH-1:0] pcnt, vcnt;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0] pcnt_ext, vcnt_ext;

  arpi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  arpi_judge u_judge (
    .cfg_i            (cfg),
    .src_port_i       (in_i.src_port),
    .vlan_inspected_i (in_i.vlan_inspected),
    .stp_forwarding_i (in_i.stp_forwarding),
    .to_own_mac_i     (in_i.to_own_mac),
    .is_reply_i       (in_i.is_reply),
    .eth_src_mac_i    (in_i.eth_src_mac),
    .eth_dst_mac_i    (in_i.eth_dst_mac),
    .sender_mac_i     (in_i.sender_mac),
    .target_mac_i     (in_i.target_mac),
    .sender_ip_i      (in_i.sender_ip),
    .target_ip_i      (in_i.target_ip),
    .judge_o          (jdg)
  );

  assign port_ok = 32'(in_i.src_port) < 32'(NUM_PORTS);
  assign vlan_ok = 32'(in_i.vlan_id) < 32'(NUM_VLANS);

  assign adv         = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !port_busy && !vlan_busy && (!s1_valid_q || adv);
  assign accept      = in_i.valid && in_i.ready;

  arpi_bank #(
    .ROWS        (NUM_PORTS),
    .IDX_W       (PORT_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_port_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (accept),
    .use_i   (jdg.counted && port_ok),
    .idx_i   (in_i.src_port),
    .slot_i  (jdg.slot),
    .adv_i   (adv),
    .count_o (pcnt),
    .busy_o  (port_busy)
  );

  arpi_bank #(
    .ROWS        (NUM_VLANS),
    .IDX_W       (VLAN_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_vlan_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (accept),
    .use_i   (jdg.counted && vlan_ok),
    .idx_i   (in_i.vlan_id),
    .slot_i  (jdg.slot),
    .adv_i   (adv),
    .count_o (vcnt),
    .busy_o  (vlan_busy)
  );

  assign pcnt_ext = {{OUT_CNT_W{1'b0}}, pcnt};
  assign vcnt_ext = {{OUT_CNT_W{1'b0}}, vcnt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_verdict_q <= jdg.verdict;
    end
    if (adv) begin
      out_verdict_q <= s1_verdict_q;
      out_pcnt_q    <= pcnt_ext[OUT_CNT_W-1:0];
      out_vcnt_q    <= vcnt_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.verdict    = out_verdict_q;
  assign out_o.port_count = out_pcnt_q;
  assign out_o.vlan_count = out_vcnt_q;

  a_no_take_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (port_busy || vlan_busy) |-> !in_i.ready
  ) else $error("item taken during counter clearing");

  a_uncounted_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_verdict_q == V_FWD_UNINSP || out_verdict_q == V_OFF ||
                     out_verdict_q == V_STP || out_verdict_q == V_OWN_MAC))
    |-> (out_pcnt_q == '0 && out_vcnt_q == '0)
  ) else $error("uncounted verdict carries a count");

  a_advance_fills_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q
  ) else $error("advanced item lost before output register");
endmodule

FILE: bench/tb_arp_packet_inspection.sv
`timescale 1ns / 1ps

module tb_arp_packet_inspection;
  import arpi_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned RAND_PER_PHASE = 257;
  localparam int unsigned RAND_PHASES    = 7;

  typedef struct packed {
    logic [PORT_W-1:0] src_port;
    logic [VLAN_W-1:0] vlan_id;
    logic              vlan_inspected;
    logic              stp_forwarding;
    logic              to_own_mac;
    logic              is_reply;
    logic [MAC_W-1:0]  eth_src_mac;
    logic [MAC_W-1:0]  eth_dst_mac;
    logic [MAC_W-1:0]  sender_mac;
    logic [MAC_W-1:0]  target_mac;
    logic [IP_W-1:0]   sender_ip;
    logic [IP_W-1:0]   target_ip;
  } arp_pkt_t;

  typedef struct packed {
    verdict_e             verdict;
    logic [OUT_CNT_W-1:0] port_count;
    logic [OUT_CNT_W-1:0] vlan_count;
  } verdict_rec_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [REG_W-1:0] pwdata;
  logic [REG_W-1:0] prdata;
  logic pready;

  arpi_in_if  in_bus ();
  arpi_out_if out_bus ();

  arp_packet_inspection DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t shadow;
  bit [OUT_CNT_W-1:0] port_tally [NUM_PORTS_DEF][SLOTS];
  bit [OUT_CNT_W-1:0] vlan_tally [NUM_VLANS_DEF][SLOTS];

  arp_pkt_t     pending_pkts [$];
  verdict_rec_t due_verdicts [$];

  int unsigned n_pushed;
  int unsigned n_checked;
  int unsigned n_settings;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned verdict_seen [9];
  int          in_gap;
  int          out_stall;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  logic        in_taken;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic ip_rejected(input logic [IP_W-1:0] ip, input logic zero_ok);
    return (ip == IP_ALL_ONES) || ((ip & IP_CLASS_DE) == IP_CLASS_DE) ||
           (!zero_ok && ip == '0);
  endfunction

  function automatic verdict_e dai_verdict(input arp_pkt_t p);
    logic zero_ok;
    zero_ok = shadow.zero_ip_ok[p.src_port];
    if (!shadow.inspect_enable) return V_OFF;
    if (!p.stp_forwarding) return V_STP;
    if (p.to_own_mac) return V_OWN_MAC;
    if (!p.vlan_inspected) return V_FWD_UNINSP;
    if (shadow.trusted[p.src_port]) return V_FWD;
    if (shadow.smac_check[p.src_port] && p.sender_mac != p.eth_src_mac) return V_SMAC;
    if (p.is_reply && shadow.tmac_check[p.src_port] && p.target_mac != p.eth_dst_mac)
      return V_DMAC;
    if (shadow.ip_check[p.src_port]) begin
      if (ip_rejected(p.sender_ip, zero_ok)) return V_SIP;
      if (p.is_reply && ip_rejected(p.target_ip, zero_ok)) return V_DIP;
    end
    return V_FWD;
  endfunction

  // counted verdicts bump their port and vlan counters, value reported after increment
  function automatic verdict_rec_t tally_verdict(input arp_pkt_t p);
    verdict_rec_t r;
    slot_e        s;
    logic         counted;
    r.verdict    = dai_verdict(p);
    r.port_count = '0;
    r.vlan_count = '0;
    s            = SLOT_FWD;
    counted      = 1'b1;
    case (r.verdict)
      V_FWD:   s = SLOT_FWD;
      V_SMAC:  s = SLOT_SMAC;
      V_DMAC:  s = SLOT_DMAC;
      V_SIP:   s = SLOT_SIP;
      V_DIP:   s = SLOT_DIP;
      default: counted = 1'b0;
    endcase
    if (counted) begin
      port_tally[p.src_port][s] = port_tally[p.src_port][s] + OUT_CNT_W'(1);
      vlan_tally[p.vlan_id][s]  = vlan_tally[p.vlan_id][s] + OUT_CNT_W'(1);
      r.port_count = port_tally[p.src_port][s];
      r.vlan_count = vlan_tally[p.vlan_id][s];
    end
    return r;
  endfunction

  function automatic arp_pkt_t good_pkt(input logic [PORT_W-1:0] port,
                                        input logic [VLAN_W-1:0] vlan);
    arp_pkt_t p;
    p.src_port       = port;
    p.vlan_id        = vlan;
    p.vlan_inspected = 1'b1;
    p.stp_forwarding = 1'b1;
    p.to_own_mac     = 1'b0;
    p.is_reply       = 1'b0;
    p.eth_src_mac    = MAC_W'({$urandom, $urandom});
    p.eth_dst_mac    = MAC_W'({$urandom, $urandom});
    p.sender_mac     = p.eth_src_mac;
    p.target_mac     = p.eth_dst_mac;
    p.sender_ip      = 32'h0A00_0001 + $urandom_range(0, 4000);
    p.target_ip      = 32'hC0A8_0001 + $urandom_range(0, 4000);
    return p;
  endfunction

  function automatic logic [IP_W-1:0] pick_ip();
    logic [IP_W-1:0] ip;
    case ($urandom_range(0, 7))
      0: ip = '0;
      1: ip = '1;
      2: ip = {3'b111, 29'($urandom)};
      3: ip = 32'hDFFF_FFFF;
      4: ip = IP_CLASS_DE;
      default: begin
        ip = $urandom;
        if (ip[31:29] == 3'b111) ip[31] = 1'b0;
      end
    endcase
    return ip;
  endfunction

  function automatic arp_pkt_t random_pkt();
    arp_pkt_t p;
    logic [VLAN_W-1:0] vlan;
    case ($urandom_range(0, 7))
      0: vlan = '0;
      1: vlan = '1;
      2: vlan = 12'd1;
      3: vlan = 12'd42;
      default: vlan = VLAN_W'($urandom);
    endcase
    p = good_pkt(PORT_W'($urandom), vlan);
    p.vlan_inspected = $urandom_range(0, 9) != 0;
    p.stp_forwarding = $urandom_range(0, 9) != 0;
    p.to_own_mac     = $urandom_range(0, 9) == 0;
    p.is_reply       = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: p.sender_mac = MAC_W'({$urandom, $urandom});
      1: p.sender_mac = p.eth_src_mac ^ (MAC_W'(1) << $urandom_range(0, MAC_W - 1));
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: p.target_mac = MAC_W'({$urandom, $urandom});
      1: p.target_mac = p.eth_dst_mac ^ (MAC_W'(1) << $urandom_range(0, MAC_W - 1));
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) p.sender_ip = pick_ip();
    if ($urandom_range(0, 2) != 0) p.target_ip = pick_ip();
    return p;
  endfunction

  function automatic logic [REG_W-1:0] rand_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return REG_W'(1) << $urandom_range(0, REG_W - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
  endtask

  task automatic offer_pkt(input arp_pkt_t p);
    pending_pkts.push_back(p);
    n_pushed++;
  endtask

  task automatic settle();
    while (n_checked < n_pushed) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [REG_W-1:0] value);
    logic [REG_W-1:0] readback;
    logic [REG_W-1:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_INSPECT_ENABLE: begin
        shadow.inspect_enable = value[0];
        want = REG_W'(value[0]);
      end
      REG_TRUSTED:    begin shadow.trusted    = value; want = value; end
      REG_SMAC_CHECK: begin shadow.smac_check = value; want = value; end
      REG_TMAC_CHECK: begin shadow.tmac_check = value; want = value; end
      REG_IP_CHECK:   begin shadow.ip_check   = value; want = value; end
      REG_ZERO_IP_OK: begin shadow.zero_ip_ok = value; want = value; end
      default: want = '0;
    endcase
    if (readback !== want)
      flag_mismatch($sformatf("register %0d readback", idx), 64'(want), 64'(readback));
  endtask

  task automatic load_config(input logic [REG_W-1:0] en, input logic [REG_W-1:0] trusted,
                             input logic [REG_W-1:0] smac, input logic [REG_W-1:0] tmac,
                             input logic [REG_W-1:0] ip, input logic [REG_W-1:0] zero_ok);
    reg_write(REG_INSPECT_ENABLE, en);
    reg_write(REG_TRUSTED, trusted);
    reg_write(REG_SMAC_CHECK, smac);
    reg_write(REG_TMAC_CHECK, tmac);
    reg_write(REG_IP_CHECK, ip);
    reg_write(REG_ZERO_IP_OK, zero_ok);
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic pick_idling(input logic calm);
    if (calm) begin
      in_idle_pct  = 0;
      out_idle_pct = 0;
    end else begin
      in_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    end
  endtask

  always @(negedge clk_i) begin : pkt_driver
    logic     offer;
    arp_pkt_t p;
    offer = in_bus.valid && !in_taken;
    if (rst_ni && !offer) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_pkts.size() != 0) begin
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(1, 14) - 1;
        end else begin
          p = pending_pkts.pop_front();
          in_bus.src_port       <= p.src_port;
          in_bus.vlan_id        <= p.vlan_id;
          in_bus.vlan_inspected <= p.vlan_inspected;
          in_bus.stp_forwarding <= p.stp_forwarding;
          in_bus.to_own_mac     <= p.to_own_mac;
          in_bus.is_reply       <= p.is_reply;
          in_bus.eth_src_mac    <= p.eth_src_mac;
          in_bus.eth_dst_mac    <= p.eth_dst_mac;
          in_bus.sender_mac     <= p.sender_mac;
          in_bus.target_mac     <= p.target_mac;
          in_bus.sender_ip      <= p.sender_ip;
          in_bus.target_ip      <= p.target_ip;
          offer = 1'b1;
        end
      end
    end
    in_bus.valid <= offer;
  end

  always @(negedge clk_i) begin : result_sink
    logic take;
    if (!rst_ni) begin
      take = 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      take = 1'b0;
    end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
      out_stall = $urandom_range(1, 14) - 1;
      take = 1'b0;
    end else begin
      take = 1'b1;
    end
    out_bus.ready <= take;
  end

  always @(posedge clk_i) begin : verdict_monitor
    logic         pkt_fire;
    logic         res_fire;
    arp_pkt_t     seen;
    verdict_rec_t due;
    pkt_fire = in_bus.valid === 1'b1 && in_bus.ready === 1'b1;
    res_fire = out_bus.valid === 1'b1 && out_bus.ready === 1'b1;
    in_taken <= pkt_fire;
    if (res_fire) begin
      if (due_verdicts.size() == 0) begin
        flag_mismatch("result with nothing due", '0, 64'(out_bus.verdict));
      end else begin
        due = due_verdicts.pop_front();
        n_checked++;
        verdict_seen[due.verdict]++;
        if (out_bus.verdict !== due.verdict)
          flag_mismatch("verdict", 64'(due.verdict), 64'(out_bus.verdict));
        if (out_bus.port_count !== due.port_count)
          flag_mismatch("port_count", 64'(due.port_count), 64'(out_bus.port_count));
        if (out_bus.vlan_count !== due.vlan_count)
          flag_mismatch("vlan_count", 64'(due.vlan_count), 64'(out_bus.vlan_count));
      end
    end
    if (pkt_fire) begin
      seen.src_port       = in_bus.src_port;
      seen.vlan_id        = in_bus.vlan_id;
      seen.vlan_inspected = in_bus.vlan_inspected;
      seen.stp_forwarding = in_bus.stp_forwarding;
      seen.to_own_mac     = in_bus.to_own_mac;
      seen.is_reply       = in_bus.is_reply;
      seen.eth_src_mac    = in_bus.eth_src_mac;
      seen.eth_dst_mac    = in_bus.eth_dst_mac;
      seen.sender_mac     = in_bus.sender_mac;
      seen.target_mac     = in_bus.target_mac;
      seen.sender_ip      = in_bus.sender_ip;
      seen.target_ip      = in_bus.target_ip;
      due_verdicts.push_back(tally_verdict(seen));
    end
    if (pkt_fire || res_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    arp_pkt_t p;
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_bus.valid          = 1'b0;
    in_bus.src_port       = '0;
    in_bus.vlan_id        = '0;
    in_bus.vlan_inspected = 1'b0;
    in_bus.stp_forwarding = 1'b0;
    in_bus.to_own_mac     = 1'b0;
    in_bus.is_reply       = 1'b0;
    in_bus.eth_src_mac    = '0;
    in_bus.eth_dst_mac    = '0;
    in_bus.sender_mac     = '0;
    in_bus.target_mac     = '0;
    in_bus.sender_ip      = '0;
    in_bus.target_ip      = '0;
    out_bus.ready         = 1'b0;
    in_taken  = 1'b0;
    in_gap    = 0;
    out_stall = 0;
    shadow    = '0;
    pick_idling(1'b0);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset settings: inspection off drops everything uncounted
    p = good_pkt(0, 0);
    offer_pkt(p);
    p = good_pkt('1, '1);
    p.stp_forwarding = 1'b0;
    p.to_own_mac     = 1'b1;
    offer_pkt(p);
    p = good_pkt(7, 100);
    p.is_reply  = 1'b1;
    p.sender_ip = '1;
    offer_pkt(p);
    settle();

    pick_idling(1'b0);
    load_config(32'd1, 32'h0000_0008, '1, '1, '1, 32'h0000_0020);
    p = good_pkt(0, 0);
    offer_pkt(p);
    offer_pkt(p);
    p.stp_forwarding = 1'b0;
    offer_pkt(p);
    p.to_own_mac = 1'b1;
    offer_pkt(p);
    p.stp_forwarding = 1'b1;
    offer_pkt(p);
    p = good_pkt(0, 0);
    p.vlan_inspected = 1'b0;
    offer_pkt(p);
    p = good_pkt(3, 9);
    p.sender_mac = ~p.eth_src_mac;
    p.sender_ip  = '1;
    offer_pkt(p);
    p = good_pkt(0, 9);
    p.sender_mac = ~p.eth_src_mac;
    offer_pkt(p);
    p = good_pkt(0, 9);
    p.is_reply   = 1'b1;
    p.target_mac = ~p.eth_dst_mac;
    offer_pkt(p);
    p.is_reply = 1'b0;
    offer_pkt(p);
    p = good_pkt(0, 9);
    p.sender_ip = '1;
    offer_pkt(p);
    p.sender_ip = IP_CLASS_DE;
    offer_pkt(p);
    p.sender_ip = 32'hDFFF_FFFF;
    offer_pkt(p);
    p.sender_ip = '0;
    offer_pkt(p);
    p.src_port = 5;
    offer_pkt(p);
    p = good_pkt(0, 9);
    p.is_reply  = 1'b1;
    p.target_ip = '1;
    offer_pkt(p);
    p.is_reply = 1'b0;
    offer_pkt(p);
    p.is_reply  = 1'b1;
    p.target_ip = 32'hF000_0001;
    offer_pkt(p);
    p.target_ip = '0;
    offer_pkt(p);
    p.src_port = 5;
    offer_pkt(p);
    p = good_pkt('1, '1);
    p.eth_src_mac = '1;
    p.sender_mac  = '1;
    p.eth_dst_mac = '1;
    p.target_mac  = '1;
    offer_pkt(p);
    p = good_pkt(0, 0);
    p.eth_src_mac = '0;
    p.sender_mac  = '0;
    offer_pkt(p);
    p = good_pkt(1, 0);
    p.is_reply   = 1'b1;
    p.sender_mac = ~p.eth_src_mac;
    p.target_mac = ~p.eth_dst_mac;
    offer_pkt(p);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick_idling(ph == RAND_PHASES - 1);
      case (ph)
        0: load_config(32'd1, '0, '1, '1, '1, '0);
        1: load_config(32'd1, '0, '0, '0, '0, '0);
        2: load_config(32'hFFFF_FFFE, rand_mask(), rand_mask(), rand_mask(), rand_mask(),
                       rand_mask());
        3: load_config(32'd1, '1, rand_mask(), rand_mask(), rand_mask(), rand_mask());
        4: load_config(32'd1, rand_mask(), '1, '1, '1, '1);
        5: load_config(32'd1, rand_mask(), rand_mask(), rand_mask(), rand_mask(),
                       rand_mask());
        default: load_config(32'd1, '0, '1, '1, '1, rand_mask());
      endcase
      for (int k = 0; k < RAND_PER_PHASE; k++) offer_pkt(random_pkt());
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (due_verdicts.size() != 0) begin
      $display("%0d expected verdicts never arrived", due_verdicts.size());
      mismatches += due_verdicts.size();
    end
    $display("checked %0d verdicts under %0d register settings, %0d mismatches",
             n_checked, n_settings, mismatches);
    $display("fwd %0d uninsp %0d off %0d stp %0d own %0d smac %0d dmac %0d sip %0d dip %0d",
             verdict_seen[V_FWD], verdict_seen[V_FWD_UNINSP], verdict_seen[V_OFF],
             verdict_seen[V_STP], verdict_seen[V_OWN_MAC], verdict_seen[V_SMAC],
             verdict_seen[V_DMAC], verdict_seen[V_SIP], verdict_seen[V_DIP]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
